@@ sv/apsp_pkg.sv @@
`timescale 1ns / 1ps

package apsp_pkg;

   localparam int DEFAULT_MAX_NODES = 64;

   localparam int CMD_W    = 2;
   localparam int NODE_W   = 6;
   localparam int DIST_W   = 32;
   localparam int NC_W     = 7;
   localparam int KIND_W   = 2;

   localparam logic [NC_W-1:0]   NC_RESET = 7'd64;
   localparam logic [DIST_W-1:0] DIST_INF = 32'hFFFF_FFFF;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_WRITE_ACK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RUN_DONE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ_DATA = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_DIAG,
      ST_ROW_REQ,
      ST_ROW_LATCH,
      ST_PAIR_REQ,
      ST_PAIR_UPD
   } state_type;

   // saturating add: infinity in, or a sum reaching all ones, gives infinity
   function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
      logic [DIST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (a == DIST_INF || b == DIST_INF || s >= {1'b0, DIST_INF}) begin
         return DIST_INF;
      end
      return s[DIST_W-1:0];
   endfunction

endpackage

@@ sv/all_pairs_shortest_path.sv @@
`timescale 1ns / 1ps
// Write: reply registered at accept; one word per cycle while the reply slot is free.
// Read: registered memory read (ST_READ_WAIT), then registered reply; next word after that.
// Run: zeroes the diagonal, then per k and i latches d[i][k], per j relaxes d[i][j];
//   paced by the single shared add/compare unit and one-write-per-cycle memory.
// Reset (synchronous, active high) clears the sequencer, the reply slot and sets
//   node_count to 64; the distance memory holds garbage until written.
module all_pairs_shortest_path #(
   parameter int MAX_NODES = apsp_pkg::DEFAULT_MAX_NODES
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration word: node_count
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [apsp_pkg::NC_W-1:0]     csr_node_count,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [apsp_pkg::CMD_W-1:0]    req_command,
   input  logic [apsp_pkg::NODE_W-1:0]   req_row,
   input  logic [apsp_pkg::NODE_W-1:0]   req_col,
   input  logic [apsp_pkg::DIST_W-1:0]   req_weight,
   input  logic                          req_no_edge,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [apsp_pkg::KIND_W-1:0]   rsp_reply_kind,
   output logic [apsp_pkg::DIST_W-1:0]   rsp_distance,
   output logic                          rsp_unreachable
);
   import apsp_pkg::*;

   localparam int IDX_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = 1 << ADDR_W;
   localparam int CNT_W   = $clog2(MAX_NODES + 1);
   localparam int CMP_W   = (CNT_W > NC_W) ? CNT_W : NC_W;

   // distance matrix, addressed {row, col}
   logic [DIST_W-1:0] mem [DEPTH];

   state_type         state_ff, state_in;
   logic [NC_W-1:0]   node_count_ff;
   logic [IDX_W-1:0]  k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [DIST_W-1:0] ik_ff, ik_in;          // d[i][k], fixed over one row pass
   logic [DIST_W-1:0] rd_a_ff, rd_b_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_unr_ff, rsp_unr_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, rd_a_addr, rd_b_addr;
   logic [DIST_W-1:0] mem_wdata;

   logic [CNT_W-1:0]  n_used;
   logic [IDX_W-1:0]  last_idx;
   logic              in_square, out_free, req_take;
   logic [IDX_W-1:0]  req_r, req_c;
   logic [DIST_W-1:0] via;

   // clamp node_count: 0 acts as 1, above MAX_NODES acts as MAX_NODES
   always_comb begin
      if (node_count_ff == '0) begin
         n_used = CNT_W'(1);
      end else if (CMP_W'(node_count_ff) > CMP_W'(MAX_NODES)) begin
         n_used = CNT_W'(MAX_NODES);
      end else begin
         n_used = CNT_W'(node_count_ff);
      end
   end

   assign last_idx  = IDX_W'(n_used - CNT_W'(1));
   assign in_square = (CMP_W'(req_row) < CMP_W'(n_used)) && (CMP_W'(req_col) < CMP_W'(n_used));
   assign req_r     = IDX_W'(req_row);
   assign req_c     = IDX_W'(req_col);

   // reply slot frees as its word leaves; a new request can land the same edge
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // the one shared relaxation unit
   assign via = sat_add(ik_ff, rd_a_ff);

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      ik_in        = ik_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_unr_in   = rsp_unr_ff;
      mem_we       = 1'b0;
      mem_waddr    = {i_ff, j_ff};
      mem_wdata    = rd_b_ff;
      rd_a_addr    = {req_r, req_c};
      rd_b_addr    = {i_ff, j_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_command)
                  CMD_WRITE: begin
                     mem_we       = in_square;
                     mem_waddr    = {req_r, req_c};
                     mem_wdata    = req_no_edge ? DIST_INF : req_weight;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_WRITE_ACK;
                     rsp_dist_in  = '0;
                     rsp_unr_in   = 1'b0;
                  end
                  CMD_RUN: begin
                     i_in     = '0;
                     state_in = ST_DIAG;
                  end
                  CMD_READ: begin
                     if (in_square) begin
                        state_in = ST_READ_WAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_READ_DATA;
                        rsp_dist_in  = DIST_INF;
                        rsp_unr_in   = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_WRITE_ACK;
                     rsp_dist_in  = '0;
                     rsp_unr_in   = 1'b0;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_READ_DATA;
            rsp_dist_in  = rd_a_ff;
            rsp_unr_in   = (rd_a_ff == DIST_INF);
            state_in     = ST_IDLE;
         end
         ST_DIAG: begin
            mem_we    = 1'b1;
            mem_waddr = {i_ff, i_ff};
            mem_wdata = '0;
            if (i_ff == last_idx) begin
               i_in     = '0;
               k_in     = '0;
               state_in = ST_ROW_REQ;
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         ST_ROW_REQ: begin
            rd_a_addr = {i_ff, k_ff};
            state_in  = ST_ROW_LATCH;
         end
         ST_ROW_LATCH: begin
            ik_in    = rd_a_ff;
            j_in     = '0;
            state_in = ST_PAIR_REQ;
         end
         ST_PAIR_REQ: begin
            rd_a_addr = {k_ff, j_ff};
            rd_b_addr = {i_ff, j_ff};
            state_in  = ST_PAIR_UPD;
         end
         ST_PAIR_UPD: begin
            // d[i][k] and d[k][j] do not change during pass k, so caching is safe
            mem_we    = (i_ff != j_ff) && (rd_b_ff > via);
            mem_waddr = {i_ff, j_ff};
            mem_wdata = via;
            if (j_ff != last_idx) begin
               j_in     = j_ff + IDX_W'(1);
               state_in = ST_PAIR_REQ;
            end else if (i_ff != last_idx) begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_ROW_REQ;
            end else if (k_ff != last_idx) begin
               k_in     = k_ff + IDX_W'(1);
               i_in     = '0;
               state_in = ST_ROW_REQ;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_RUN_DONE;
               rsp_dist_in  = '0;
               rsp_unr_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // distance memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NC_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_node_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      ik_ff       <= ik_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_unr_ff  <= rsp_unr_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reply_kind  = rsp_kind_ff;
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_unreachable = rsp_unr_ff;

endmodule
